// ----- rtl/dttb_pkg.sv -----
`default_nettype none

package dttb_pkg;

    // field widths of the stream payloads
    localparam int MODE_W    = 3;
    localparam int CPU_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int SLOT_W    = 32;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // saturation value of the done counter
    localparam logic [COUNT_W-1:0] DONE_MAX = '1;

    // loader id, minus one in two's complement
    localparam logic [CPU_W-1:0] LOADER_ID = '1;

    // request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_RESTART    = 3'd0,
        MODE_PASS       = 3'd1,
        MODE_RETIRE     = 3'd2,
        MODE_NEW_SLOT   = 3'd3,
        MODE_SCHED_DONE = 3'd4
    } mode_t;

endpackage

`default_nettype wire

// ----- rtl/descending_turn_token_with_barrier_top.sv -----
`default_nettype none

// Turn token with a per-slot barrier. Each transaction on the s_ side carries
// one request (restart order, pass turn, retire processor, new slot,
// scheduling done) and yields exactly one result on the m_ side with the turn
// holder, barrier flag, participant count and slot number after the request.
// The turn runs from the highest active processor below processor_count down
// to processor 0 and then to the loader (-1). Throughput is one transaction
// per cycle while m_tready does not stall the result; an accepted request
// passes the input register, then the state update loads the result register.
// The per-cycle path is the priority search and population count over the
// MAX_PROCESSORS-bit active mask. processor_count is written through cfg_wr_en
// and takes effect on the next request.
module descending_turn_token_with_barrier_top #(
    parameter int MAX_PROCESSORS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration: processor_count
    input  wire logic                               cfg_wr_en,
    input  wire logic [dttb_pkg::COUNT_W-1:0]       cfg_wr_data,
    // request stream; tdata: mode[2:0], cpu_id[9:3], zero[15:10]
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [dttb_pkg::IN_DATA_W-1:0]     s_tdata,
    // result stream; tdata: turn_holder[6:0], barrier_released[7],
    // participant_count[14:8], time_slot[46:15], zero[47]
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [dttb_pkg::OUT_DATA_W-1:0]         m_tdata
);

    localparam int MW = MAX_PROCESSORS;
    localparam int CW = dttb_pkg::CPU_W;
    localparam int NW = dttb_pkg::COUNT_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_PROCESSORS);

    // bits below lim set
    function automatic logic [MW-1:0] low_mask(input logic [NW-1:0] lim);
        logic [MW-1:0] m;
        m = '0;
        for (int i = 0; i < MW; i++)
        begin
            m[i] = (NW'(i) < lim);
        end
        return m;
    endfunction

    // highest set bit index, or loader id if none
    function automatic logic [CW-1:0] top_bit(input logic [MW-1:0] v);
        logic [CW-1:0] r;
        r = dttb_pkg::LOADER_ID;
        for (int i = 0; i < MW; i++)
        begin
            if (v[i])
            begin
                r = CW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [NW-1:0] pop_count(input logic [MW-1:0] v);
        logic [NW-1:0] c;
        c = '0;
        for (int i = 0; i < MW; i++)
        begin
            c = c + NW'(v[i]);
        end
        return c;
    endfunction

    // configuration and block state
    logic [NW-1:0]                  proc_count_reg;
    logic [MW-1:0]                  active_mask_reg, active_mask_next;
    logic [CW-1:0]                  turn_reg, turn_next;
    logic [NW-1:0]                  done_reg, done_next;
    logic                           release_reg, release_next;
    logic [dttb_pkg::SLOT_W-1:0]    slot_reg, slot_next;

    // input stage
    logic                           in_valid_reg;
    logic [dttb_pkg::MODE_W-1:0]    in_mode_reg;
    logic [CW-1:0]                  in_cpu_reg;

    // result stage
    logic                           out_valid_reg;
    logic [CW-1:0]                  out_turn_reg;
    logic                           out_release_reg;
    logic [NW-1:0]                  out_count_reg;
    logic [dttb_pkg::SLOT_W-1:0]    out_slot_reg;

    logic                           advance;
    logic [NW-1:0]                  lim_n;
    logic [MW-1:0]                  lim_mask;
    logic [NW-1:0]                  part_now;
    logic [NW-1:0]                  part_next;

    // pipeline flow control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign lim_n    = (proc_count_reg > MAX_N) ? MAX_N : proc_count_reg;
    assign lim_mask = low_mask(lim_n);
    assign part_now = pop_count(active_mask_reg & lim_mask) + NW'(1);

    // state update for the request in the input stage
    always_comb
    begin
        active_mask_next = active_mask_reg;
        turn_next        = turn_reg;
        done_next        = done_reg;
        release_next     = release_reg;
        slot_next        = slot_reg;
        unique case (dttb_pkg::mode_t'(in_mode_reg))
            dttb_pkg::MODE_RESTART:
            begin
                active_mask_next = active_mask_reg | lim_mask;
                turn_next        = lim_n - NW'(1);
            end
            dttb_pkg::MODE_PASS:
            begin
                if (in_cpu_reg == dttb_pkg::LOADER_ID)
                begin
                    turn_next = top_bit(active_mask_reg & lim_mask);
                end
                else if (in_cpu_reg[CW-1] || (in_cpu_reg == '0))
                begin
                    turn_next = dttb_pkg::LOADER_ID;
                end
                else
                begin
                    turn_next = top_bit(active_mask_reg & low_mask(in_cpu_reg));
                end
            end
            dttb_pkg::MODE_RETIRE:
            begin
                for (int i = 0; i < MW; i++)
                begin
                    if (in_cpu_reg == CW'(i))
                    begin
                        active_mask_next[i] = 1'b0;
                    end
                end
            end
            dttb_pkg::MODE_NEW_SLOT:
            begin
                slot_next    = slot_reg + 32'd1;
                turn_next    = top_bit(active_mask_reg & lim_mask);
                done_next    = '0;
                release_next = 1'b0;
            end
            dttb_pkg::MODE_SCHED_DONE:
            begin
                if (done_reg != dttb_pkg::DONE_MAX)
                begin
                    done_next = done_reg + NW'(1);
                end
                if (done_next >= part_now)
                begin
                    release_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign part_next = pop_count(active_mask_next & lim_mask) + NW'(1);

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_count_reg  <= '0;
            active_mask_reg <= '0;
            turn_reg        <= dttb_pkg::LOADER_ID;
            done_reg        <= '0;
            release_reg     <= 1'b0;
            slot_reg        <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                proc_count_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                active_mask_reg <= active_mask_next;
                turn_reg        <= turn_next;
                done_reg        <= done_next;
                release_reg     <= release_next;
                slot_reg        <= slot_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tdata[dttb_pkg::MODE_W-1:0];
            in_cpu_reg  <= s_tdata[dttb_pkg::MODE_W +: CW];
        end
        if (advance)
        begin
            out_turn_reg    <= turn_next;
            out_release_reg <= release_next;
            out_count_reg   <= part_next;
            out_slot_reg    <= slot_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_slot_reg, out_count_reg, out_release_reg, out_turn_reg};

`ifndef SYNTH
    // release is only ever set after at least one done report
    a_release_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        release_reg |-> (done_reg != '0))
        else $error("barrier released with zero done count");

    // a new slot always drops the barrier
    a_new_slot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_mode_reg == dttb_pkg::MODE_NEW_SLOT)) |=> !release_reg)
        else $error("barrier still released after new slot");

    // turn holder is the loader or a processor in range
    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        !turn_reg[CW-1] |-> (turn_reg < CW'(MAX_PROCESSORS)))
        else $error("turn holder out of range");

    // every processed request produces a pending result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request without result");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PROCS = 64;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 110;

    // spare request codes, no state change
    localparam logic [dttb_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [dttb_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    // most negative cpu id, below the loader
    localparam logic [dttb_pkg::CPU_W-1:0] CPU_LOWEST = 7'h40;

    // laid out as on m_tdata, last member in the lowest bits
    typedef struct packed {
        logic [dttb_pkg::SLOT_W-1:0]  slot;
        logic [dttb_pkg::COUNT_W-1:0] members;
        logic                         released;
        logic [dttb_pkg::CPU_W-1:0]   turn;
    } slot_report_t;

    typedef struct packed {
        logic                         is_cfg;
        logic [dttb_pkg::COUNT_W-1:0] cfg_val;
        logic [dttb_pkg::MODE_W-1:0]  mode;
        logic [dttb_pkg::CPU_W-1:0]   cpu;
        logic                         known;
        slot_report_t                 want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [dttb_pkg::COUNT_W-1:0]    cfg_wr_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [dttb_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [dttb_pkg::OUT_DATA_W-1:0] m_tdata;

    // shadow state of the turn token
    logic [MAX_PROCS-1:0]         act_mask;
    int                           turn_now;
    int                           done_cnt;
    logic                         release_now;
    logic [dttb_pkg::SLOT_W-1:0]  slot_cnt;
    logic [dttb_pkg::COUNT_W-1:0] proc_count;

    slot_report_t pending_reports[$];
    stim_row_t    directed_rows[$];
    slot_report_t got_report;
    slot_report_t want_report;
    int           err_count = 0;
    int           stall_left = 0;
    int           ready_left = 0;

    descending_turn_token_with_barrier_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_run();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(50, 200);
        return $urandom_range(1, 8);
    endfunction

    function automatic int active_limit();
        return (proc_count > MAX_PROCS) ? MAX_PROCS : int'(proc_count);
    endfunction

    // highest active processor at or below start, else the loader
    function automatic int highest_active_from(int start);
        for (int i = start; i >= 0; i--)
        begin
            if (act_mask[i])
                return i;
        end
        return -1;
    endfunction

    // loader plus active processors below the limit
    function automatic int participant_total();
        int n;
        int c;
        n = active_limit();
        c = 1;
        for (int i = 0; i < n; i++)
        begin
            if (act_mask[i])
                c++;
        end
        return c;
    endfunction

    // update the shadow state for one request and build its report
    function automatic slot_report_t apply_request(logic [dttb_pkg::MODE_W-1:0] mode,
                                                   logic [dttb_pkg::CPU_W-1:0] cpu_raw);
        int n;
        int cpu;
        slot_report_t rep;
        n = active_limit();
        cpu = $signed(cpu_raw);
        case (mode)
            dttb_pkg::MODE_RESTART:
            begin
                for (int i = 0; i < n; i++)
                    act_mask[i] = 1'b1;
                turn_now = n - 1;
            end
            dttb_pkg::MODE_PASS:
            begin
                if (cpu == -1)
                    turn_now = highest_active_from(n - 1);
                else if (cpu <= 0)
                    turn_now = -1;
                else
                    turn_now = highest_active_from(cpu - 1);
            end
            dttb_pkg::MODE_RETIRE:
            begin
                if (cpu >= 0 && cpu < MAX_PROCS)
                    act_mask[cpu] = 1'b0;
            end
            dttb_pkg::MODE_NEW_SLOT:
            begin
                slot_cnt = slot_cnt + 1'b1;
                turn_now = highest_active_from(n - 1);
                done_cnt = 0;
                release_now = 1'b0;
            end
            dttb_pkg::MODE_SCHED_DONE:
            begin
                if (done_cnt < int'(dttb_pkg::DONE_MAX))
                    done_cnt++;
                if (done_cnt >= participant_total())
                    release_now = 1'b1;
            end
            default:
            begin
            end
        endcase
        rep.turn = dttb_pkg::CPU_W'(turn_now);
        rep.released = release_now;
        rep.members = dttb_pkg::COUNT_W'(participant_total());
        rep.slot = slot_cnt;
        return rep;
    endfunction

    // one request transaction; the expectation is queued at acceptance
    task automatic send_request(logic [dttb_pkg::MODE_W-1:0] mode,
                                logic [dttb_pkg::CPU_W-1:0] cpu,
                                logic known, slot_report_t want, logic quiet);
        int gap;
        slot_report_t pred;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(dttb_pkg::IN_DATA_W - dttb_pkg::MODE_W - dttb_pkg::CPU_W){1'b0}},
                    cpu, mode};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        pred = apply_request(mode, cpu);
        pending_reports.push_back(known ? want : pred);
    endtask

    // stop sending and let every pending result come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_proc_count(logic [dttb_pkg::COUNT_W-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        proc_count = value;
    endtask

    task automatic add_cfg(logic [dttb_pkg::COUNT_W-1:0] value);
        directed_rows.push_back('{1'b1, value, '0, '0, 1'b0, '0});
    endtask

    task automatic add_item(logic [dttb_pkg::MODE_W-1:0] mode,
                            logic [dttb_pkg::CPU_W-1:0] cpu);
        directed_rows.push_back('{1'b0, '0, mode, cpu, 1'b0, '0});
    endtask

    task automatic add_known(logic [dttb_pkg::MODE_W-1:0] mode,
                             logic [dttb_pkg::CPU_W-1:0] cpu,
                             logic [dttb_pkg::CPU_W-1:0] turn, logic released,
                             logic [dttb_pkg::COUNT_W-1:0] members,
                             logic [dttb_pkg::SLOT_W-1:0] slot);
        directed_rows.push_back('{1'b0, '0, mode, cpu, 1'b1,
                                  '{slot: slot, members: members,
                                    released: released, turn: turn}});
    endtask

    // result side: check each transaction, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got_report = m_tdata[dttb_pkg::OUT_DATA_W-2:0];
            if (pending_reports.size() == 0)
            begin
                $error("result transaction with nothing expected, tdata %h", m_tdata);
                err_count++;
            end
            else
            begin
                want_report = pending_reports.pop_front();
                if (got_report.turn !== want_report.turn)
                begin
                    $error("turn_holder: expected %0d, got %0d",
                           $signed(want_report.turn), $signed(got_report.turn));
                    err_count++;
                end
                if (got_report.released !== want_report.released)
                begin
                    $error("barrier_released: expected %0d, got %0d",
                           want_report.released, got_report.released);
                    err_count++;
                end
                if (got_report.members !== want_report.members)
                begin
                    $error("participant_count: expected %0d, got %0d",
                           want_report.members, got_report.members);
                    err_count++;
                end
                if (got_report.slot !== want_report.slot)
                begin
                    $error("time_slot: expected %0d, got %0d",
                           want_report.slot, got_report.slot);
                    err_count++;
                end
                if (m_tdata[dttb_pkg::OUT_DATA_W-1] !== 1'b0)
                begin
                    $error("pad: expected 0, got %b", m_tdata[dttb_pkg::OUT_DATA_W-1]);
                    err_count++;
                end
            end
        end
        if (stall_left == 0 && ready_left == 0)
        begin
            stall_left = pick_gap();
            ready_left = pick_run();
        end
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            ready_left--;
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [dttb_pkg::COUNT_W-1:0] phase_counts[PHASES];
        logic [dttb_pkg::MODE_W-1:0]  mode;
        logic [dttb_pkg::CPU_W-1:0]   cpu;
        logic                         quiet;
        int                           r;
        int                           n;
        int                           items;

        act_mask = '0;
        turn_now = -1;
        done_cnt = 0;
        release_now = 1'b0;
        slot_cnt = '0;
        proc_count = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, count extremes, loader and id extremes
        add_known(dttb_pkg::MODE_PASS, dttb_pkg::LOADER_ID, dttb_pkg::LOADER_ID,
                  1'b0, 7'd1, 32'd0);
        add_known(dttb_pkg::MODE_RESTART, 7'd0, dttb_pkg::LOADER_ID, 1'b0, 7'd1, 32'd0);
        add_known(dttb_pkg::MODE_SCHED_DONE, dttb_pkg::LOADER_ID, dttb_pkg::LOADER_ID,
                  1'b1, 7'd1, 32'd0);
        add_known(MODE_SPARE_5, 7'd0, dttb_pkg::LOADER_ID, 1'b1, 7'd1, 32'd0);
        add_known(dttb_pkg::MODE_NEW_SLOT, 7'd0, dttb_pkg::LOADER_ID, 1'b0, 7'd1, 32'd1);
        add_cfg(7'd64);
        add_known(dttb_pkg::MODE_RESTART, 7'd0, 7'd63, 1'b0, 7'd65, 32'd1);
        add_item(dttb_pkg::MODE_PASS, 7'd63);
        add_item(dttb_pkg::MODE_RETIRE, 7'd63);
        add_item(dttb_pkg::MODE_PASS, dttb_pkg::LOADER_ID);
        add_known(dttb_pkg::MODE_PASS, 7'd0, dttb_pkg::LOADER_ID, 1'b0, 7'd64, 32'd1);
        add_known(dttb_pkg::MODE_PASS, CPU_LOWEST, dttb_pkg::LOADER_ID,
                  1'b0, 7'd64, 32'd1);
        add_item(dttb_pkg::MODE_RETIRE, CPU_LOWEST);
        add_item(dttb_pkg::MODE_RETIRE, dttb_pkg::LOADER_ID);
        add_item(dttb_pkg::MODE_RETIRE, 7'd0);
        add_item(dttb_pkg::MODE_PASS, 7'd1);
        add_item(dttb_pkg::MODE_SCHED_DONE, 7'd63);
        add_item(MODE_SPARE_7, 7'h55);
        add_cfg(7'd127);
        add_known(dttb_pkg::MODE_RESTART, 7'd0, 7'd63, 1'b0, 7'd65, 32'd1);
        add_known(dttb_pkg::MODE_NEW_SLOT, 7'd0, 7'd63, 1'b0, 7'd65, 32'd2);
        add_cfg(7'd0);
        add_known(dttb_pkg::MODE_PASS, dttb_pkg::LOADER_ID, dttb_pkg::LOADER_ID,
                  1'b0, 7'd1, 32'd2);
        add_item(dttb_pkg::MODE_PASS, 7'd63);
        add_cfg(7'd1);
        add_item(dttb_pkg::MODE_RESTART, 7'd0);
        add_item(dttb_pkg::MODE_SCHED_DONE, 7'd0);
        add_item(dttb_pkg::MODE_SCHED_DONE, 7'd0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_proc_count(directed_rows[i].cfg_val);
            else
                send_request(directed_rows[i].mode, directed_rows[i].cpu,
                             directed_rows[i].known, directed_rows[i].want, 1'b0);
        end

        // random phases, each under its own processor count
        phase_counts = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd33, 7'd65, 7'd2, 7'd63, 7'd5};
        phase_counts[6] = dttb_pkg::COUNT_W'($urandom_range(0, 127));
        phase_counts[8] = dttb_pkg::COUNT_W'($urandom_range(0, 8));
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_proc_count(phase_counts[ph]);
            quiet = ($urandom_range(0, 3) == 0);
            // phase 3 floods the barrier so the done counter saturates
            items = (ph == 3) ? 2 * PHASE_ITEMS : PHASE_ITEMS;
            for (int k = 0; k < items; k++)
            begin
                n = active_limit();
                r = $urandom_range(0, 99);
                cpu = dttb_pkg::CPU_W'($urandom_range(0, 127));
                if (ph == 3)
                    mode = (r < 95) ? dttb_pkg::MODE_SCHED_DONE
                                    : dttb_pkg::MODE_W'($urandom_range(0, 7));
                else if (k == 0 || r < 10)
                    mode = dttb_pkg::MODE_RESTART;
                else if (r < 45)
                begin
                    // well-formed pass: the holder hands the turn on
                    mode = dttb_pkg::MODE_PASS;
                    cpu = dttb_pkg::CPU_W'(turn_now);
                end
                else if (r < 55)
                    mode = dttb_pkg::MODE_PASS;
                else if (r < 63)
                begin
                    mode = dttb_pkg::MODE_RETIRE;
                    if (n > 0 && $urandom_range(0, 3) != 0)
                        cpu = dttb_pkg::CPU_W'($urandom_range(0, n - 1));
                end
                else if (r < 70)
                    mode = dttb_pkg::MODE_NEW_SLOT;
                else if (r < 88)
                    mode = dttb_pkg::MODE_SCHED_DONE;
                else
                    mode = dttb_pkg::MODE_W'($urandom_range(0, 7));
                send_request(mode, cpu, 1'b0, '0, quiet);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dttb_pkg.sv
rtl/descending_turn_token_with_barrier_top.sv
tb/sv/testbench.sv
